[hdl/scv_pkg.sv]
// Shared types, constants and helpers of the spring chain Verlet step block.
package scv_pkg;

  localparam int FRAC_BITS = 16;
  localparam int KICK_SHIFT = FRAC_BITS + 1;
  localparam int ENERGY_SHIFT = 2 * FRAC_BITS + 1;
  localparam int NUM_PARTICLES = 3;
  localparam int DIV_STEPS = 64;

  localparam logic [2:0] CFG_SPRING_CONSTANT = 3'd0;
  localparam logic [2:0] CFG_TIME_STEP = 3'd1;
  localparam logic [2:0] CFG_MASS_LEFT = 3'd2;
  localparam logic [2:0] CFG_MASS_MIDDLE = 3'd3;
  localparam logic [2:0] CFG_MASS_RIGHT = 3'd4;

  localparam logic ACTION_LOAD = 1'b0;
  localparam logic ACTION_STEP = 1'b1;

  localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic               action;
    logic [1:0]         particle;
    logic signed [31:0] load_position;
    logic signed [31:0] load_velocity;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] position_left;
    logic signed [31:0] position_middle;
    logic signed [31:0] position_right;
    logic signed [31:0] velocity_left;
    logic signed [31:0] velocity_middle;
    logic signed [31:0] velocity_right;
    logic [47:0]        kinetic_energy;
    logic [47:0]        potential_energy;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [31:0] data;
  } cfg_write_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    if (x > 66'sh0_7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end else if (x < -66'sh0_8000_0000) begin
      return -32'sh8000_0000;
    end
    return x[31:0];
  endfunction

endpackage

[hdl/scv_ifs.sv]
// Handshake channels of the spring chain Verlet step block.
interface scv_item_if;
  import scv_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface scv_result_if;
  import scv_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface scv_cfg_if;
  import scv_pkg::*;
  logic       valid;
  logic       ready;
  cfg_write_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

[hdl/spring_chain_verlet_step.sv]
// Three-mass spring chain integrated by velocity Verlet in signed fixed point.
// One transaction at a time: steps and loads share one 33x33 multiplier and a radix-2 divider
// that works out the three accelerations in turn; the five energy terms use the multiplier. A
// new item is taken while the previous result still waits on the output register.
// Configuration writes are taken at any time.
module spring_chain_verlet_step (
  input logic      clk_i,
  input logic      rst_ni,
  scv_item_if.sink item_i,
  scv_result_if.source result_o,
  scv_cfg_if.sink  cfg_i
);
  import scv_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_KICK_MUL, S_KICK_ADD, S_DRIFT_MUL, S_DRIFT_ADD,
    S_ACC_MUL, S_ACC_LD, S_ACC_DIV, S_ACC_WR,
    S_SQ_MUL, S_LO_MUL, S_HI_MUL, S_ENER_ADD, S_OUT
  } state_e;

  state_e state_q;
  logic [1:0] idx_q;
  logic [5:0] cnt_q;
  logic step_q, kick2_q, epe_q, neg_q, fzero_q, out_valid_q;

  logic [31:0] kappa_q;
  logic [15:0] dt_q;
  logic [31:0] mass_q [NUM_PARTICLES];

  logic signed [31:0] x_q [NUM_PARTICLES];
  logic signed [31:0] v_q [NUM_PARTICLES];
  logic signed [31:0] a_q [NUM_PARTICLES];

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod_q;
  logic [31:0] sqhi_q;
  logic [63:0] plo_q;
  logic [31:0] rem_q;
  logic [63:0] dq_q;
  logic [47:0] ke_q, pe_q;
  out_item_t out_q;

  logic signed [34:0] diff;
  logic signed [31:0] dsat;
  logic signed [32:0] pdiff;
  logic [31:0] emag, emul, dmass;
  logic signed [65:0] kick_sum, drift_sum, fmag;
  logic [32:0] div_sh;
  logic div_ge;
  logic [32:0] qclamp;
  logic signed [33:0] qsigned;
  logic signed [31:0] acc_new;
  logic [95:0] etot, eterm;
  logic [47:0] eterm_sat, ener_old;
  logic [48:0] ener_sum;
  logic [47:0] ener_new;
  logic in_fire, last_idx;

  assign item_i.ready = (state_q == S_IDLE);
  assign in_fire = item_i.valid && item_i.ready;
  assign cfg_i.ready = 1'b1;
  assign result_o.valid = out_valid_q;
  assign result_o.data = out_q;

  always_comb begin
    case (idx_q)
      2'd0: diff = 35'(x_q[1]) - 35'(x_q[0]);
      2'd1: diff = 35'(x_q[2]) - (35'(x_q[1]) <<< 1) + 35'(x_q[0]);
      default: diff = 35'(x_q[1]) - 35'(x_q[2]);
    endcase
    dsat = sat32(66'(diff));
    dmass = (idx_q == 2'd3) ? mass_q[0] : mass_q[idx_q];
    pdiff = (idx_q == 2'd0) ? 33'(x_q[1]) - 33'(x_q[0]) : 33'(x_q[2]) - 33'(x_q[1]);
    if (epe_q) begin
      emag = pdiff[32] ? 32'(-pdiff) : pdiff[31:0];
      emul = kappa_q;
    end else begin
      emag = v_q[idx_q][31] ? 32'(-v_q[idx_q]) : v_q[idx_q];
      emul = dmass;
    end
    last_idx = epe_q ? (idx_q == 2'd1) : (idx_q == 2'd2);
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_KICK_MUL: begin
        mul_a = 33'(a_q[idx_q]);
        mul_b = {17'b0, dt_q};
      end
      S_DRIFT_MUL: begin
        mul_a = 33'(v_q[idx_q]);
        mul_b = {17'b0, dt_q};
      end
      S_ACC_MUL: begin
        mul_a = {1'b0, kappa_q};
        mul_b = 33'(dsat);
      end
      S_SQ_MUL: begin
        mul_a = {1'b0, emag};
        mul_b = {1'b0, emag};
      end
      S_LO_MUL: begin
        mul_a = {1'b0, emul};
        mul_b = {1'b0, prod_q[31:0]};
      end
      S_HI_MUL: begin
        mul_a = {1'b0, emul};
        mul_b = {1'b0, sqhi_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    kick_sum = 66'(v_q[idx_q]) + (prod_q >>> KICK_SHIFT);
    drift_sum = 66'(x_q[idx_q]) + (prod_q >>> FRAC_BITS);
    fmag = prod_q[65] ? -prod_q : prod_q;
    div_sh = {rem_q, dq_q[63]};
    div_ge = div_sh >= {1'b0, dmass};
    qclamp = (dq_q > 64'h8000_0000) ? 33'h1_0000_0000 : dq_q[32:0];
    qsigned = neg_q ? -34'(qclamp) : 34'(qclamp);
    if (dmass == '0) begin
      acc_new = neg_q ? -32'sh8000_0000 : (fzero_q ? 32'sh0 : 32'sh7FFF_FFFF);
    end else begin
      acc_new = sat32(66'(qsigned));
    end
    etot = {prod_q[63:0], 32'b0} + {32'b0, plo_q};
    eterm = etot >> ENERGY_SHIFT;
    eterm_sat = (|eterm[95:48]) ? MAX48 : eterm[47:0];
    ener_old = epe_q ? pe_q : ke_q;
    ener_sum = {1'b0, ener_old} + {1'b0, eterm_sat};
    ener_new = ener_sum[48] ? MAX48 : ener_sum[47:0];
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q <= '0;
      cnt_q <= '0;
      step_q <= 1'b0;
      kick2_q <= 1'b0;
      epe_q <= 1'b0;
      neg_q <= 1'b0;
      fzero_q <= 1'b0;
      out_valid_q <= 1'b0;
      kappa_q <= 32'd65536;
      dt_q <= 16'd655;
      for (int k = 0; k < NUM_PARTICLES; k++) begin
        mass_q[k] <= 32'd65536;
        x_q[k] <= '0;
        v_q[k] <= '0;
        a_q[k] <= '0;
      end
    end else begin
      if (cfg_i.valid) begin
        case (cfg_i.data.index)
          CFG_SPRING_CONSTANT: kappa_q <= cfg_i.data.data;
          CFG_TIME_STEP: dt_q <= cfg_i.data.data[15:0];
          CFG_MASS_LEFT: mass_q[0] <= cfg_i.data.data;
          CFG_MASS_MIDDLE: mass_q[1] <= cfg_i.data.data;
          CFG_MASS_RIGHT: mass_q[2] <= cfg_i.data.data;
          default: begin
          end
        endcase
      end
      if (result_o.valid && result_o.ready && state_q != S_OUT) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            idx_q <= '0;
            step_q <= item_i.data.action;
            kick2_q <= 1'b0;
            epe_q <= 1'b0;
            ke_q <= '0;
            pe_q <= '0;
            if (item_i.data.action == ACTION_STEP) begin
              state_q <= S_KICK_MUL;
            end else begin
              if (item_i.data.particle != 2'd3) begin
                x_q[item_i.data.particle] <= item_i.data.load_position;
                v_q[item_i.data.particle] <= item_i.data.load_velocity;
              end
              state_q <= S_ACC_MUL;
            end
          end
        end
        S_KICK_MUL: state_q <= S_KICK_ADD;
        S_KICK_ADD: begin
          v_q[idx_q] <= sat32(kick_sum);
          if (idx_q != 2'd2) begin
            idx_q <= idx_q + 2'd1;
            state_q <= S_KICK_MUL;
          end else begin
            idx_q <= '0;
            state_q <= kick2_q ? S_SQ_MUL : S_DRIFT_MUL;
          end
        end
        S_DRIFT_MUL: state_q <= S_DRIFT_ADD;
        S_DRIFT_ADD: begin
          x_q[idx_q] <= sat32(drift_sum);
          if (idx_q != 2'd2) begin
            idx_q <= idx_q + 2'd1;
            state_q <= S_DRIFT_MUL;
          end else begin
            idx_q <= '0;
            state_q <= S_ACC_MUL;
          end
        end
        S_ACC_MUL: state_q <= S_ACC_LD;
        S_ACC_LD: begin
          neg_q <= prod_q[65];
          fzero_q <= (prod_q == '0);
          dq_q <= fmag[63:0];
          rem_q <= '0;
          cnt_q <= '0;
          state_q <= S_ACC_DIV;
        end
        S_ACC_DIV: begin
          rem_q <= div_ge ? 32'(div_sh - {1'b0, dmass}) : div_sh[31:0];
          dq_q <= {dq_q[62:0], div_ge};
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'(DIV_STEPS - 1)) begin
            state_q <= S_ACC_WR;
          end
        end
        S_ACC_WR: begin
          a_q[idx_q] <= acc_new;
          if (idx_q != 2'd2) begin
            idx_q <= idx_q + 2'd1;
            state_q <= S_ACC_MUL;
          end else begin
            idx_q <= '0;
            kick2_q <= 1'b1;
            state_q <= step_q ? S_KICK_MUL : S_SQ_MUL;
          end
        end
        S_SQ_MUL: state_q <= S_LO_MUL;
        S_LO_MUL: begin
          sqhi_q <= prod_q[63:32];
          state_q <= S_HI_MUL;
        end
        S_HI_MUL: begin
          plo_q <= prod_q[63:0];
          state_q <= S_ENER_ADD;
        end
        S_ENER_ADD: begin
          if (epe_q) begin
            pe_q <= ener_new;
          end else begin
            ke_q <= ener_new;
          end
          if (!last_idx) begin
            idx_q <= idx_q + 2'd1;
            state_q <= S_SQ_MUL;
          end else if (!epe_q) begin
            idx_q <= '0;
            epe_q <= 1'b1;
            state_q <= S_SQ_MUL;
          end else begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_q || result_o.ready) begin
            out_q.position_left <= x_q[0];
            out_q.position_middle <= x_q[1];
            out_q.position_right <= x_q[2];
            out_q.velocity_left <= v_q[0];
            out_q.velocity_middle <= v_q[1];
            out_q.velocity_right <= v_q[2];
            out_q.kinetic_energy <= ke_q;
            out_q.potential_energy <= pe_q;
            out_valid_q <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q != S_IDLE)
    else $error("block idle right after taking a transaction");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && (!out_valid_q || result_o.ready)) |=>
      (out_valid_q && state_q == S_IDLE))
    else $error("finished result not loaded");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_OUT)
    else $error("result valid raised outside output state");

endmodule

[dv/tb_spring_chain_verlet_step.sv]
// Testbench of the spring chain Verlet step block with its own predictor and a scoreboard.
module tb_spring_chain_verlet_step;
  import scv_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int DRAIN_CYCLES = 300;
  localparam int LONG_HOLD = 2000;

  class chain_scoreboard;
    logic [31:0] kappa, mass_l, mass_m, mass_r;
    logic [15:0] dt;
    longint pos[3], vel[3], acc[3];
    out_item_t expected_states[$];
    int mismatches, unexpected, checked;

    function new();
      kappa = 32'd65536; dt = 16'd655;
      mass_l = 32'd65536; mass_m = 32'd65536; mass_r = 32'd65536;
      for (int i = 0; i < 3; i++) begin
        pos[i] = 0; vel[i] = 0; acc[i] = 0;
      end
      mismatches = 0; unexpected = 0; checked = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] value);
      case (idx)
        CFG_SPRING_CONSTANT: kappa = value;
        CFG_TIME_STEP: dt = value[15:0];
        CFG_MASS_LEFT: mass_l = value;
        CFG_MASS_MIDDLE: mass_m = value;
        CFG_MASS_RIGHT: mass_r = value;
        default: ;
      endcase
    endfunction

    function longint clamp_word(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
    endfunction

    function longint accel_from(longint diff, logic [31:0] m);
      logic signed [95:0] k96, d96, frc;
      logic [95:0] mag, q;
      k96 = {64'd0, kappa};
      d96 = clamp_word(diff);
      frc = k96 * d96;
      if (m == 0) begin
        if (frc > 0) return 64'sd2147483647;
        if (frc < 0) return -64'sd2147483648;
        return 0;
      end
      mag = frc < 0 ? -frc : frc;
      q = mag / {64'd0, m};
      if (q > 96'h8000_0000) q = 96'h8000_0000;
      return clamp_word(frc < 0 ? -longint'(q[63:0]) : longint'(q[63:0]));
    endfunction

    function void update_accel();
      acc[0] = accel_from(pos[1] - pos[0], mass_l);
      acc[1] = accel_from(pos[2] - 2 * pos[1] + pos[0], mass_m);
      acc[2] = accel_from(pos[1] - pos[2], mass_r);
    endfunction

    function void kick_half();
      for (int i = 0; i < 3; i++)
        vel[i] = clamp_word(vel[i] + ((acc[i] * longint'({48'd0, dt})) >>> KICK_SHIFT));
    endfunction

    function logic [47:0] energy_term(logic [31:0] c, longint v);
      logic [63:0] mg;
      logic [127:0] prod;
      mg = v < 0 ? -v : v;
      prod = {96'd0, c} * {64'd0, mg * mg};
      prod = prod >> ENERGY_SHIFT;
      return prod > {80'd0, MAX48} ? MAX48 : prod[47:0];
    endfunction

    function logic [47:0] add_capped(logic [47:0] a, logic [47:0] b);
      logic [48:0] s;
      s = a + b;
      return s[48] ? MAX48 : s[47:0];
    endfunction

    function void note_item(in_item_t it);
      out_item_t r;
      logic [31:0] ms[3];
      logic [47:0] ke, pe;
      if (it.action == ACTION_LOAD) begin
        if (it.particle < 3) begin
          pos[it.particle] = longint'(it.load_position);
          vel[it.particle] = longint'(it.load_velocity);
        end
        update_accel();
      end else begin
        kick_half();
        for (int i = 0; i < 3; i++)
          pos[i] = clamp_word(pos[i] + ((vel[i] * longint'({48'd0, dt})) >>> FRAC_BITS));
        update_accel();
        kick_half();
      end
      ms[0] = mass_l; ms[1] = mass_m; ms[2] = mass_r;
      ke = '0; pe = '0;
      for (int i = 0; i < 3; i++) ke = add_capped(ke, energy_term(ms[i], vel[i]));
      for (int i = 0; i < 2; i++) pe = add_capped(pe, energy_term(kappa, pos[i+1] - pos[i]));
      r.position_left = pos[0][31:0];
      r.position_middle = pos[1][31:0];
      r.position_right = pos[2][31:0];
      r.velocity_left = vel[0][31:0];
      r.velocity_middle = vel[1][31:0];
      r.velocity_right = vel[2][31:0];
      r.kinetic_energy = ke;
      r.potential_energy = pe;
      expected_states.push_back(r);
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_r;
      if (expected_states.size() == 0) begin
        unexpected++;
        if (unexpected <= 10) $display("unexpected result %h", got);
        return;
      end
      exp_r = expected_states.pop_front();
      checked++;
      if (got.position_left !== exp_r.position_left ||
          got.position_middle !== exp_r.position_middle ||
          got.position_right !== exp_r.position_right ||
          got.velocity_left !== exp_r.velocity_left ||
          got.velocity_middle !== exp_r.velocity_middle ||
          got.velocity_right !== exp_r.velocity_right ||
          got.kinetic_energy !== exp_r.kinetic_energy ||
          got.potential_energy !== exp_r.potential_energy) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch at result %0d", checked);
          $display("  exp x %h %h %h v %h %h %h ke %h pe %h", exp_r.position_left,
                   exp_r.position_middle, exp_r.position_right, exp_r.velocity_left,
                   exp_r.velocity_middle, exp_r.velocity_right, exp_r.kinetic_energy,
                   exp_r.potential_energy);
          $display("  got x %h %h %h v %h %h %h ke %h pe %h", got.position_left,
                   got.position_middle, got.position_right, got.velocity_left,
                   got.velocity_middle, got.velocity_right, got.kinetic_energy,
                   got.potential_energy);
        end
      end
    endfunction

    function int pending();
      return expected_states.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #5 clk_i = ~clk_i;

  scv_item_if item_bus();
  scv_result_if result_bus();
  scv_cfg_if cfg_bus();

  spring_chain_verlet_step dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .item_i(item_bus),
    .result_o(result_bus),
    .cfg_i(cfg_bus)
  );

  chain_scoreboard sb = new();
  bit quiet_mode = 1'b0;
  bit hold_request = 1'b0;
  int items_sent = 0;
  int loads_sent = 0;
  int cfg_sets = 0;
  longint cycles = 0;

  initial begin
    item_bus.valid = 1'b0;
    item_bus.data = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.data = '0;
    result_bus.ready = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_spring_chain_verlet_step: done, errors");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_bus.valid && result_bus.ready) sb.check_result(result_bus.data);
  end

  initial begin
    @(posedge clk_i);
    forever begin
      if (hold_request) begin
        result_bus.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        hold_request = 1'b0;
      end else if (!quiet_mode && $urandom_range(0, 9) == 0) begin
        result_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end else begin
        result_bus.ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk_i);
      end
    end
  end

  task automatic send_item(in_item_t it);
    item_bus.valid <= 1'b1;
    item_bus.data <= it;
    do @(posedge clk_i); while (!item_bus.ready);
    sb.note_item(it);
    items_sent++;
    if (it.action == ACTION_LOAD) loads_sent++;
  endtask

  task automatic maybe_idle();
    if (!quiet_mode && $urandom_range(0, 5) == 0) begin
      item_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    item_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_settings(logic [31:0] k, logic [31:0] t, logic [31:0] ml,
                                logic [31:0] mm, logic [31:0] mr);
    logic [31:0] vals[5];
    cfg_write_t w;
    vals = '{k, t, ml, mm, mr};
    for (int i = 0; i < 5; i++) begin
      w.index = i[2:0];
      w.data = vals[i];
      cfg_bus.valid <= 1'b1;
      cfg_bus.data <= w;
      do @(posedge clk_i); while (!cfg_bus.ready);
      sb.set_reg(w.index, w.data);
    end
    cfg_bus.valid <= 1'b0;
    cfg_sets++;
  endtask

  function automatic logic [31:0] pick_value(bit wild);
    case (wild ? $urandom_range(0, 3) : $urandom_range(4, 6))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      2: return $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
      3: return $urandom();
      4: return 32'($signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
      5: return 32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
      default: return $urandom();
    endcase
  endfunction

  function automatic in_item_t make_item(logic act, logic [1:0] p, logic [31:0] x,
                                         logic [31:0] v);
    in_item_t it;
    it.action = act;
    it.particle = p;
    it.load_position = x;
    it.load_velocity = v;
    return it;
  endfunction

  task automatic random_items(int count);
    int n;
    n = 0;
    while (n < count) begin
      if ($urandom_range(0, 9) < 7) begin
        repeat ($urandom_range(1, 3)) begin
          send_item(make_item(ACTION_LOAD, 2'($urandom_range(0, 2)), pick_value(1'b0),
                              pick_value(1'b0)));
          n++;
          maybe_idle();
        end
        repeat ($urandom_range(3, 15)) begin
          send_item(make_item(ACTION_STEP, 2'($urandom()), $urandom(), $urandom()));
          n++;
          maybe_idle();
        end
      end else begin
        send_item(make_item(1'($urandom()), 2'($urandom()), pick_value(1'b1),
                            pick_value(1'b1)));
        n++;
        maybe_idle();
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(make_item(ACTION_LOAD, 2'd0, 32'h7FFF_FFFF, 32'h8000_0000));
    send_item(make_item(ACTION_LOAD, 2'd1, 32'h8000_0000, 32'h7FFF_FFFF));
    send_item(make_item(ACTION_LOAD, 2'd2, 32'h0, 32'hFFFF_FFFF));
    send_item(make_item(ACTION_STEP, 2'd0, 32'h0, 32'h0));
    send_item(make_item(ACTION_STEP, 2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_item(make_item(ACTION_LOAD, 2'd3, 32'h1234_5678, 32'h8765_4321));
    send_item(make_item(ACTION_LOAD, 2'd0, 32'hFFFF_0000, 32'h0001_0000));
    send_item(make_item(ACTION_LOAD, 2'd1, 32'h0, 32'h0));
    send_item(make_item(ACTION_LOAD, 2'd2, 32'h0001_0000, 32'hFFFF_0000));
    repeat (4) send_item(make_item(ACTION_STEP, 2'd1, 32'h0, 32'h0));
    send_item(make_item(ACTION_LOAD, 2'd0, 32'hAAAA_AAAA, 32'h5555_5555));
    send_item(make_item(ACTION_LOAD, 2'd1, 32'h5555_5555, 32'hAAAA_AAAA));
    send_item(make_item(ACTION_LOAD, 2'd2, 32'hAAAA_AAAA, 32'h5555_5555));
    repeat (3) send_item(make_item(ACTION_STEP, 2'd2, 32'h0, 32'h0));
    drain_results();

    write_settings(32'hFFFF_FFFF, 32'd65535, 32'd1, 32'd1, 32'd1);
    send_item(make_item(ACTION_LOAD, 2'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_item(make_item(ACTION_LOAD, 2'd2, 32'h8000_0000, 32'h8000_0000));
    repeat (3) send_item(make_item(ACTION_STEP, 2'd0, 32'h0, 32'h0));
    hold_request = 1'b1;
    random_items(140);
    drain_results();

    write_settings(32'd0, 32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    random_items(130);
    drain_results();

    write_settings($urandom(), 32'd0, 32'd0, 32'd0, 32'd0);
    random_items(130);
    drain_results();

    write_settings(32'd65536, 32'd655, 32'd65536, 32'd65536, 32'd65536);
    random_items(150);
    drain_results();

    for (int ph = 0; ph < 2; ph++) begin
      write_settings($urandom_range(32'h0001_0000, 32'h0010_0000), $urandom_range(100, 5000),
                     $urandom_range(32'h4000, 32'h0010_0000),
                     $urandom_range(32'h4000, 32'h0010_0000),
                     $urandom_range(32'h4000, 32'h0010_0000));
      random_items(120);
      drain_results();
    end

    quiet_mode = 1'b1;
    write_settings($urandom(), $urandom_range(1, 65535), $urandom(), $urandom(), $urandom());
    random_items(110);
    drain_results();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("items %0d (loads %0d), results checked %0d, setting groups %0d",
             items_sent, loads_sent, sb.checked, cfg_sets);
    $display("mismatches %0d, unexpected results %0d", sb.mismatches, sb.unexpected);
    if (sb.mismatches == 0 && sb.unexpected == 0 && sb.pending() == 0) begin
      $display("tb_spring_chain_verlet_step: done, clean");
    end else begin
      $display("tb_spring_chain_verlet_step: done, errors");
    end
    $finish;
  end

endmodule
